[rtl/core/dpp_pkg.sv]
// ----------------------------------------------------------------------------
// dpp_pkg
// Shared types and constants for the depth pixel to point core.
// ----------------------------------------------------------------------------
package dpp_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WIDTH_W    = 13;
    localparam int ROW_REG_W  = 63;
    localparam int UNIT_W     = 25;
    localparam int RAW_W      = 16;
    localparam int COEF_W     = 21;
    localparam int DEPTH_W    = UNIT_W + RAW_W;
    localparam int DL_W       = 20;
    localparam int DH_W       = DEPTH_W - DL_W;
    localparam int CFG_IDX_W  = 3;

    localparam logic [UNIT_W-1:0]  UNIT_RESET  = UNIT_W'(16777);
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(640);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_ROW0    = 3'd0,
        REG_INV_ROW1    = 3'd1,
        REG_INV_ROW2    = 3'd2,
        REG_DEPTH_UNIT  = 3'd3,
        REG_IMAGE_WIDTH = 3'd4,
        REG_ENABLE      = 3'd5
    } dpp_reg_t;

    typedef struct packed {
        logic [RAW_W-1:0] depth_raw;
        logic             frame_start;
    } dpp_pixel_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               point_valid;
    } dpp_point_t;

    // load strobes for the lane stages
    typedef struct packed {
        logic ld2;
        logic ld3;
        logic ld4;
    } dpp_stage_en_t;

endpackage

[rtl/core/dpp_lane.sv]
// ----------------------------------------------------------------------------
// dpp_lane
// One row of the inverse matrix: s = c0*col + c1*row + c2, then floor(s*d/2^26)
// saturated to 32 bits. Stages 2 to 4 of the core pipeline.
// ----------------------------------------------------------------------------
module dpp_lane (
    input  logic                          aclk,
    input  dpp_pkg::dpp_stage_en_t        stage_en,
    input  logic [dpp_pkg::ROW_REG_W-1:0] coef_row,
    input  logic [dpp_pkg::COL_W-1:0]     col,
    input  logic [dpp_pkg::ROW_W-1:0]     row,
    input  logic [dpp_pkg::DEPTH_W-1:0]   depth,
    output logic signed [31:0]            coord
);
    import dpp_pkg::*;

    logic signed [COEF_W-1:0] c0, c1, c2;
    logic signed [33:0]       p0_full, p1_full;
    logic signed [32:0]       p0_reg, p0_next, p1_reg, p1_next;
    logic signed [34:0]       s_reg, s_next;
    logic signed [56:0]       a_full;
    logic signed [55:0]       b_full;
    logic signed [55:0]       a_reg, a_next;
    logic signed [54:0]       b_reg, b_next;
    logic signed [76:0]       acc;
    logic signed [50:0]       r_full;

    assign c0 = $signed(coef_row[COEF_W-1:0]);
    assign c1 = $signed(coef_row[2*COEF_W-1:COEF_W]);
    assign c2 = $signed(coef_row[3*COEF_W-1:2*COEF_W]);

    assign p0_full = c0 * $signed({1'b0, col});
    assign p1_full = c1 * $signed({1'b0, row});
    assign p0_next = p0_full[32:0];
    assign p1_next = p1_full[32:0];

    assign s_next = 35'(p0_reg) + 35'(p1_reg) + 35'(c2);

    assign a_full = s_reg * $signed({1'b0, depth[DEPTH_W-1:DL_W]});
    assign b_full = s_reg * $signed({1'b0, depth[DL_W-1:0]});
    assign a_next = a_full[55:0];
    assign b_next = b_full[54:0];

    assign acc    = (77'(a_reg) <<< DL_W) + 77'(b_reg);
    assign r_full = acc[76:26];

    always_comb begin
        if (r_full[50:31] == {20{r_full[50]}}) begin
            coord = r_full[31:0];
        end else if (r_full[50]) begin
            coord = 32'sh8000_0000;
        end else begin
            coord = 32'sh7fff_ffff;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en.ld2) begin
            p0_reg <= p0_next;
            p1_reg <= p1_next;
        end
        if (stage_en.ld3) begin
            s_reg <= s_next;
        end
        if (stage_en.ld4) begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

endmodule

[rtl/core/depth_pixel_to_point_core.sv]
// ----------------------------------------------------------------------------
// depth_pixel_to_point_core
// Back-projects a raster depth stream into signed Q16.16 camera-frame points.
//
//   channel  | ports                     | moves
//   ---------+---------------------------+-------------------------------
//   pixel in | s_valid s_ready s_pixel   | one depth sample per transaction
//   point out| m_valid m_ready m_point   | one point per enabled pixel
//   config   | cfg_we cfg_index cfg_wdata| register write, no read-back
//
// One pixel per cycle while the output is not stalled; the pipeline has five register
// stages: input capture, first multiplies, coefficient sum, depth multiply, wide add
// with saturation.
// Reset clears counters, stage valids and loads register defaults.
// Each stage holds while the one after it is full and not moving; bubbles close up.
// ----------------------------------------------------------------------------
module depth_pixel_to_point_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  dpp_pkg::dpp_pixel_t           s_pixel,
    output logic                          m_valid,
    input  logic                          m_ready,
    output dpp_pkg::dpp_point_t           m_point,
    input  logic                          cfg_we,
    input  logic [dpp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dpp_pkg::ROW_REG_W-1:0] cfg_wdata
);
    import dpp_pkg::*;

    logic [ROW_REG_W-1:0] inv_row0_reg, inv_row1_reg, inv_row2_reg;
    logic [UNIT_W-1:0]    unit_reg;
    logic [WIDTH_W-1:0]   width_reg;
    logic                 enable_reg;

    logic [COL_W-1:0]     col_reg, col_next, col_cur;
    logic [ROW_W-1:0]     row_reg, row_next, row_cur;
    logic [WIDTH_W-1:0]   eff_width;
    logic [WIDTH_W-1:0]   col_inc;
    logic                 take;

    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic                 rdy1, rdy2, rdy3, rdy4, rdy5;
    logic [COL_W-1:0]     col1_reg;
    logic [ROW_W-1:0]     row1_reg;
    logic [RAW_W-1:0]     raw1_reg;
    logic                 nz2_reg, nz3_reg, nz4_reg;
    logic [DEPTH_W-1:0]   d2_reg, d2_next, d3_reg;
    dpp_stage_en_t        stage_en;
    logic signed [31:0]   coord_x, coord_y, coord_z;
    dpp_point_t           point_next;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_row0_reg <= '0;
            inv_row1_reg <= '0;
            inv_row2_reg <= '0;
            unit_reg     <= UNIT_RESET;
            width_reg    <= WIDTH_RESET;
            enable_reg   <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_INV_ROW0:    inv_row0_reg <= cfg_wdata;
                REG_INV_ROW1:    inv_row1_reg <= cfg_wdata;
                REG_INV_ROW2:    inv_row2_reg <= cfg_wdata;
                REG_DEPTH_UNIT:  unit_reg     <= cfg_wdata[UNIT_W-1:0];
                REG_IMAGE_WIDTH: width_reg    <= cfg_wdata[WIDTH_W-1:0];
                REG_ENABLE:      enable_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ready chain, last stage is the output register
    assign rdy5    = !m_valid || m_ready;
    assign rdy4    = !v4_reg || rdy5;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign take    = s_valid && s_ready;

    // raster position
    assign eff_width = (width_reg == '0 || width_reg > WIDTH_W'(MAX_WIDTH)) ?
                       WIDTH_W'(MAX_WIDTH) : width_reg;
    assign col_cur   = s_pixel.frame_start ? '0 : col_reg;
    assign row_cur   = s_pixel.frame_start ? '0 : row_reg;
    assign col_inc   = WIDTH_W'(col_cur) + WIDTH_W'(1);

    always_comb begin
        if (col_inc >= eff_width) begin
            col_next = '0;
            row_next = row_cur + ROW_W'(1);
        end else begin
            col_next = col_inc[COL_W-1:0];
            row_next = row_cur;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (take) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            m_valid <= 1'b0;
        end else begin
            if (rdy1) v1_reg  <= take && enable_reg;
            if (rdy2) v2_reg  <= v1_reg;
            if (rdy3) v3_reg  <= v2_reg;
            if (rdy4) v4_reg  <= v3_reg;
            if (rdy5) m_valid <= v4_reg;
        end
    end

    assign stage_en.ld2 = rdy2 && v1_reg;
    assign stage_en.ld3 = rdy3 && v2_reg;
    assign stage_en.ld4 = rdy4 && v3_reg;

    assign d2_next = DEPTH_W'(unit_reg * raw1_reg);

    always_ff @(posedge aclk) begin
        if (take && rdy1) begin
            col1_reg <= col_cur;
            row1_reg <= row_cur;
            raw1_reg <= s_pixel.depth_raw;
        end
        if (stage_en.ld2) begin
            d2_reg  <= d2_next;
            nz2_reg <= (raw1_reg != '0);
        end
        if (stage_en.ld3) begin
            d3_reg  <= d2_reg;
            nz3_reg <= nz2_reg;
        end
        if (stage_en.ld4) begin
            nz4_reg <= nz3_reg;
        end
    end

    dpp_lane u_lane_x (
        .aclk     (aclk),
        .stage_en (stage_en),
        .coef_row (inv_row0_reg),
        .col      (col1_reg),
        .row      (row1_reg),
        .depth    (d3_reg),
        .coord    (coord_x)
    );

    dpp_lane u_lane_y (
        .aclk     (aclk),
        .stage_en (stage_en),
        .coef_row (inv_row1_reg),
        .col      (col1_reg),
        .row      (row1_reg),
        .depth    (d3_reg),
        .coord    (coord_y)
    );

    dpp_lane u_lane_z (
        .aclk     (aclk),
        .stage_en (stage_en),
        .coef_row (inv_row2_reg),
        .col      (col1_reg),
        .row      (row1_reg),
        .depth    (d3_reg),
        .coord    (coord_z)
    );

    // zero depth gives an invalid point at the origin
    always_comb begin
        point_next.point_valid = nz4_reg;
        point_next.point_x     = nz4_reg ? coord_x : '0;
        point_next.point_y     = nz4_reg ? coord_y : '0;
        point_next.point_z     = nz4_reg ? coord_z : '0;
    end

    always_ff @(posedge aclk) begin
        if (rdy5 && v4_reg) begin
            m_point <= point_next;
        end
    end

    // checks
    a_invalid_at_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_point.point_valid |->
            m_point.point_x == 0 && m_point.point_y == 0 && m_point.point_z == 0)
        else $error("invalid point with non-zero coordinates");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    a_drop_when_disabled: assert property (@(posedge aclk) disable iff (!aresetn)
        take && !enable_reg |=> !v1_reg)
        else $error("transaction entered pipeline while disabled");

    a_frame_start_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        take && s_pixel.frame_start |=> (col_reg == '0) != (row_reg == '0))
        else $error("frame start did not restart raster position");

endmodule
